// ----- rtl/core/tccs_pkg.sv -----
// Shared types and constants for the text console with cursor and scroll.
// No dependencies; used by the channel interfaces and the top level.
package tccs_pkg;

  // Item opcodes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Character codes that the put path interprets
  localparam logic [7:0] CH_STOP      = 8'h24;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // Attribute register value after reset
  localparam logic [7:0] ATTR_RESET = 8'h07;

  typedef struct packed {
    logic        op;
    logic [7:0]  character;
    logic [10:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic        halted;
  } rsp_t;

endpackage

// ----- rtl/core/tccs_if.sv -----
// Valid/ready channel interfaces: request, response and attribute write.
// Depends on tccs_pkg for the payload types.
interface tccs_req_if;
  logic              valid;
  logic              ready;
  tccs_pkg::req_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tccs_rsp_if;
  logic              valid;
  logic              ready;
  tccs_pkg::rsp_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tccs_cfg_if;
  logic              valid;
  logic              ready;
  logic [7:0]        data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/tccs_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tccs_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/text_console_cursor_scroll_top.sv -----
// Text console top level: cursor sequencer, scroll/clear sweeps, output register.
// Depends on tccs_pkg, the channel interfaces in tccs_if.sv and tccs_ram.
//
//  channel | dir | beat payload                                      | ready
//  --------+-----+---------------------------------------------------+-----------------
//  req_i   | in  | op, character, cell_index                         | idle state only
//  rsp_o   | out | cell_value, cursor_column, cursor_row, halted     | downstream
//  cfg_i   | in  | text attribute byte                               | always
//
// After reset the block sweeps the screen RAM to zero before taking its first request.
// A read passes through the read-wait and result-load states after the accepting
// cycle; a simple put writes one cell and then loads the result; a tab writes
// TAB_SPACES cells. A scroll copies rows up through the single RAM port pair and
// then blanks the bottom row. A new request is accepted while the previous result
// still waits in the output register; the sequencer only stalls at its final step if
// that slot is full and not being taken downstream.
module text_console_cursor_scroll_top #(
  parameter int COLUMNS    = 80,
  parameter int ROWS       = 25,
  parameter int TAB_SPACES = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tccs_req_if.sink         req_i,
  tccs_rsp_if.source       rsp_o,
  tccs_cfg_if.sink         cfg_i
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int LW    = $clog2(ROWS);
  localparam int NW    = $clog2(TAB_SPACES + 1);

  // One-hot sequencer states
  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,  // post-reset zero sweep
    ST_IDLE  = 7'b0000010,
    ST_READ  = 7'b0000100,  // wait for registered RAM read
    ST_WRITE = 7'b0001000,  // write one cell, maybe advance
    ST_COPY  = 7'b0010000,  // move rows up one
    ST_ZERO  = 7'b0100000,  // blank bottom row
    ST_RESP  = 7'b1000000   // load result register
  } state_e;

  state_e          st_q, st_d;
  logic [AW-1:0]   addr_q, addr_d;     // shared sweep / read address counter
  logic            cp_vld_q, cp_vld_d; // copy write pending
  logic [AW-1:0]   cp_wr_q, cp_wr_d;
  logic            drain_q, drain_d;
  logic [CW-1:0]   col_q, col_d;
  logic [LW-1:0]   line_q, line_d;
  logic [AW-1:0]   base_q, base_d;     // line_q * COLUMNS, kept incrementally
  logic [NW-1:0]   cnt_q, cnt_d;       // cells left to write for this put
  logic            adv_q, adv_d;
  logic [7:0]      wch_q, wch_d;
  logic            stop_q, stop_d;
  logic            is_rd_q, is_rd_d;
  logic            in_rng_q, in_rng_d;
  logic [7:0]      attr_q;
  logic            rsp_vld_q;
  tccs_pkg::rsp_t  rsp_q;

  logic            req_acc;
  logic            out_load;
  logic            line_last;
  logic            col_last;
  logic            addr_last;
  logic [AW-1:0]   wr_pos;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [15:0]     ram_wdata;
  logic [15:0]     ram_rdata;

  assign req_i.ready = (st_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_load    = (st_q == ST_RESP) && (!rsp_vld_q || rsp_o.ready);

  assign line_last = (line_q == LW'(ROWS - 1));
  assign col_last  = (col_q == CW'(COLUMNS - 1));
  assign addr_last = (addr_q == AW'(CELLS - 1));
  assign wr_pos    = base_q + AW'(col_q);

  // RAM port steering: sweeps write zero, copy writes back the last read
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    case (st_q)
      ST_CLEAR, ST_ZERO: begin
        ram_we = 1'b1;
      end
      ST_COPY: begin
        ram_we    = cp_vld_q;
        ram_waddr = cp_wr_q;
        ram_wdata = ram_rdata;
      end
      ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = wr_pos;
        ram_wdata = {attr_q, wch_q};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tccs_ram #(
    .Width (16),
    .Depth (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // Sequencer
  always_comb begin
    st_d     = st_q;
    addr_d   = addr_q;
    cp_vld_d = cp_vld_q;
    cp_wr_d  = cp_wr_q;
    drain_d  = drain_q;
    col_d    = col_q;
    line_d   = line_q;
    base_d   = base_q;
    cnt_d    = cnt_q;
    adv_d    = adv_q;
    wch_d    = wch_q;
    stop_d   = stop_q;
    is_rd_d  = is_rd_q;
    in_rng_d = in_rng_q;
    case (st_q)
      ST_CLEAR: begin
        if (addr_last) begin
          addr_d = '0;
          st_d   = ST_IDLE;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (req_acc) begin
          is_rd_d  = (req_i.data.op == tccs_pkg::OP_READ);
          in_rng_d = (32'(req_i.data.cell_index) < CELLS);
          addr_d   = AW'(req_i.data.cell_index);
          cnt_d    = '0;
          if (req_i.data.op == tccs_pkg::OP_READ) begin
            st_d = ST_READ;
          end else if (stop_q) begin
            st_d = ST_RESP;
          end else begin
            case (req_i.data.character)
              tccs_pkg::CH_STOP: begin
                stop_d = 1'b1;
                st_d   = ST_RESP;
              end
              tccs_pkg::CH_NEWLINE: begin
                col_d = '0;
                if (line_last) begin
                  addr_d   = AW'(COLUMNS);
                  drain_d  = 1'b0;
                  cp_vld_d = 1'b0;
                  st_d     = ST_COPY;
                end else begin
                  line_d = line_q + LW'(1);
                  base_d = base_q + AW'(COLUMNS);
                  st_d   = ST_RESP;
                end
              end
              tccs_pkg::CH_RETURN: begin
                st_d = ST_RESP;
              end
              tccs_pkg::CH_TAB: begin
                wch_d = tccs_pkg::CH_SPACE;
                cnt_d = NW'(TAB_SPACES);
                adv_d = 1'b1;
                st_d  = ST_WRITE;
              end
              tccs_pkg::CH_BACKSPACE: begin
                if (col_q != '0) begin
                  col_d = col_q - CW'(1);
                  wch_d = tccs_pkg::CH_SPACE;
                  cnt_d = NW'(1);
                  adv_d = 1'b0;
                  st_d  = ST_WRITE;
                end else begin
                  st_d = ST_RESP;
                end
              end
              default: begin
                wch_d = req_i.data.character;
                cnt_d = NW'(1);
                adv_d = 1'b1;
                st_d  = ST_WRITE;
              end
            endcase
          end
        end
      end
      ST_READ: begin
        st_d = ST_RESP;
      end
      ST_WRITE: begin
        cnt_d = cnt_q - NW'(1);
        st_d  = (cnt_q == NW'(1)) ? ST_RESP : ST_WRITE;
        if (adv_q) begin
          if (col_last) begin
            col_d = '0;
            if (line_last) begin
              addr_d   = AW'(COLUMNS);
              drain_d  = 1'b0;
              cp_vld_d = 1'b0;
              st_d     = ST_COPY;
            end else begin
              line_d = line_q + LW'(1);
              base_d = base_q + AW'(COLUMNS);
            end
          end else begin
            col_d = col_q + CW'(1);
          end
        end
      end
      ST_COPY: begin
        // read row r+1 at addr_q, write it in the next cycle at addr_q - COLUMNS
        cp_vld_d = !drain_q;
        if (!drain_q) begin
          cp_wr_d = addr_q - AW'(COLUMNS);
          if (addr_last) begin
            drain_d = 1'b1;
          end else begin
            addr_d = addr_q + AW'(1);
          end
        end else begin
          addr_d = AW'(CELLS - COLUMNS);
          st_d   = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (addr_last) begin
          st_d = (cnt_q != '0) ? ST_WRITE : ST_RESP;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      ST_RESP: begin
        if (out_load) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_CLEAR;
      addr_q   <= '0;
      cp_vld_q <= 1'b0;
      drain_q  <= 1'b0;
      col_q    <= '0;
      line_q   <= '0;
      base_q   <= '0;
      cnt_q    <= '0;
      adv_q    <= 1'b0;
      stop_q   <= 1'b0;
      is_rd_q  <= 1'b0;
      in_rng_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      addr_q   <= addr_d;
      cp_vld_q <= cp_vld_d;
      drain_q  <= drain_d;
      col_q    <= col_d;
      line_q   <= line_d;
      base_q   <= base_d;
      cnt_q    <= cnt_d;
      adv_q    <= adv_d;
      stop_q   <= stop_d;
      is_rd_q  <= is_rd_d;
      in_rng_q <= in_rng_d;
    end
  end

  // Payload-only registers
  always_ff @(posedge clk_i) begin
    cp_wr_q <= cp_wr_d;
    wch_q   <= wch_d;
  end

  // Attribute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tccs_pkg::ATTR_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      attr_q <= cfg_i.data;
    end
  end

  // Output register; reads see the RAM word addressed by addr_q in ST_RESP
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (out_load) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rsp_q.cell_value    <= (is_rd_q && in_rng_q) ? ram_rdata : 16'h0000;
      rsp_q.cursor_column <= 7'(col_q);
      rsp_q.cursor_row    <= 5'(line_q);
      rsp_q.halted        <= stop_q;
    end
  end

  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp_q;

  // Checks
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> !ram_we)
    else $error("screen RAM written while idle");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < COLUMNS)
    else $error("cursor column out of range");

  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(line_q) < ROWS)
    else $error("cursor row out of range");

  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q)
    else $error("halt flag cleared");

  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (32'(ram_waddr) < CELLS))
    else $error("screen write address out of range");

endmodule
